>>> hdl/dsct_pkg.sv
// Package: types, codes and defaults for the delayed-start cook timer.
package dsct_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int FIELD_W           = 32;
  localparam int COOK_W            = 31;
  localparam int CODE_W            = 3;

  typedef enum logic [CODE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_WAITING  = 3'd1,
    PH_COOKING  = 3'd2,
    PH_FINISHED = 3'd3,
    PH_ERROR    = 3'd4
  } phase_t;

  localparam logic [CODE_W-1:0] ACT_TICK      = 3'd0;
  localparam logic [CODE_W-1:0] ACT_START_NOW = 3'd1;
  localparam logic [CODE_W-1:0] ACT_START_AT  = 3'd2;
  localparam logic [CODE_W-1:0] ACT_FINISH_BY = 3'd3;
  localparam logic [CODE_W-1:0] ACT_ADVANCE   = 3'd4;

  typedef struct packed {
    logic [CODE_W-1:0]  action;
    logic [FIELD_W-1:0] now;
    logic [FIELD_W-1:0] time_value;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0]         phase;
    logic signed [FIELD_W-1:0] remaining;
  } result_t;

endpackage

>>> hdl/dsct_step.sv
// Per-item step logic: phase transition, begin time update and result fields.
module dsct_step #(
  parameter int TIME_BITS = dsct_pkg::TIME_BITS_DEFAULT
) (
  input  dsct_pkg::item_t                     item,
  input  logic [dsct_pkg::COOK_W-1:0]         cook_duration,
  input  dsct_pkg::phase_t                    phase,
  input  logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] begin_time,
  output dsct_pkg::phase_t                    phase_next,
  output logic [((TIME_BITS < 32) ? TIME_BITS : 32)-1:0] begin_time_next,
  output dsct_pkg::result_t                   result
);

  localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [dsct_pkg::FIELD_W-1:0] now_m;
  logic [dsct_pkg::FIELD_W-1:0] begin_ext;
  logic [dsct_pkg::FIELD_W-1:0] elapsed;
  logic [dsct_pkg::FIELD_W-1:0] finish_start;
  logic [dsct_pkg::FIELD_W-1:0] begin_next_ext;
  logic                         start_due;
  logic                         cook_done;
  logic                         timed_ok;

  assign now_m          = dsct_pkg::FIELD_W'(item.now[TB-1:0]);
  assign begin_ext      = dsct_pkg::FIELD_W'(begin_time);
  assign elapsed        = now_m - begin_ext;
  assign finish_start   = item.time_value - {1'b0, cook_duration};
  assign start_due      = now_m >= begin_ext;
  assign cook_done      = !elapsed[dsct_pkg::FIELD_W-1] &&
                          (elapsed[dsct_pkg::COOK_W-1:0] >= cook_duration);
  assign timed_ok       = (phase == dsct_pkg::PH_IDLE) || (phase == dsct_pkg::PH_WAITING);
  assign begin_next_ext = dsct_pkg::FIELD_W'(begin_time_next);

  always_comb begin
    phase_next      = phase;
    begin_time_next = begin_time;
    unique case (item.action)
      dsct_pkg::ACT_TICK: begin
        if (phase == dsct_pkg::PH_WAITING) begin
          if (start_due) begin
            phase_next      = dsct_pkg::PH_COOKING;
            begin_time_next = item.now[TB-1:0];
          end
        end else if (phase == dsct_pkg::PH_COOKING) begin
          if (cook_done) begin
            phase_next = dsct_pkg::PH_FINISHED;
          end
        end
      end
      dsct_pkg::ACT_START_NOW: begin
        phase_next      = dsct_pkg::PH_COOKING;
        begin_time_next = item.now[TB-1:0];
      end
      dsct_pkg::ACT_START_AT: begin
        if (timed_ok) begin
          phase_next      = dsct_pkg::PH_WAITING;
          begin_time_next = item.time_value[TB-1:0];
        end
      end
      dsct_pkg::ACT_FINISH_BY: begin
        if (timed_ok) begin
          phase_next      = dsct_pkg::PH_WAITING;
          begin_time_next = finish_start[TB-1:0];
        end
      end
      dsct_pkg::ACT_ADVANCE: begin
        if ((phase == dsct_pkg::PH_ERROR) || (phase == dsct_pkg::PH_FINISHED)) begin
          phase_next = dsct_pkg::PH_IDLE;
        end else if (phase == dsct_pkg::PH_WAITING) begin
          phase_next      = dsct_pkg::PH_COOKING;
          begin_time_next = item.now[TB-1:0];
        end
      end
      default: begin
        phase_next      = phase;
        begin_time_next = begin_time;
      end
    endcase
  end

  always_comb begin
    result.phase = phase_next;
    if (phase_next == dsct_pkg::PH_COOKING) begin
      result.remaining = {1'b0, cook_duration} - (now_m - begin_next_ext);
    end else if (phase_next == dsct_pkg::PH_WAITING) begin
      result.remaining = begin_next_ext - now_m;
    end else begin
      result.remaining = '0;
    end
  end

endmodule

>>> hdl/delayed_start_cook_timer_top.sv
// Top level: input register, phase and begin-time state, result register.
// An item goes into the input register, then through the step logic into the result register.
// Throughput: one item per cycle when not stalled; step logic is one compare/subtract pass.
// State and result registers advance on a held item when the result side is empty or taken.
// Synchronous reset: phase idle, begin time 0, cook duration 0, both stages empty.
module delayed_start_cook_timer_top #(
  parameter int TIME_BITS = dsct_pkg::TIME_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  dsct_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output dsct_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [dsct_pkg::COOK_W-1:0] cfg_wdata
);

  localparam int TB = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic                        item_held;
  dsct_pkg::item_t             item_q;
  logic [dsct_pkg::COOK_W-1:0] cook_duration;
  dsct_pkg::phase_t            phase;
  logic [TB-1:0]               begin_time;
  dsct_pkg::phase_t            phase_next;
  logic [TB-1:0]               begin_time_next;
  dsct_pkg::result_t           step_result;
  logic                        step_go;

  assign step_go    = item_held && (!result_valid || result_ready);
  assign item_ready = !item_held || step_go;

  dsct_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .item            (item_q),
    .cook_duration   (cook_duration),
    .phase           (phase),
    .begin_time      (begin_time),
    .phase_next      (phase_next),
    .begin_time_next (begin_time_next),
    .result          (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cook_duration <= '0;
    end else if (cfg_we) begin
      cook_duration <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= dsct_pkg::PH_IDLE;
      begin_time <= '0;
    end else if (step_go) begin
      phase      <= phase_next;
      begin_time <= begin_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_go) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      result <= step_result;
    end
  end

endmodule
